// ----- rtl/cfa_pkg.sv -----
// Package with the request, status and policy codes and the controller state type.
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int unsigned TagW   = 11;
  localparam int unsigned StartW = 10;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [1:0] STAT_ALLOC   = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_CLEARED = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_CLEAR,
    S_DONE
  } state_e;

endpackage

// ----- rtl/contiguous_fit_allocator.sv -----
// Contiguous fit allocator: cell tag memory with scan, mark and clear sequencer.
// Allocate: a scan over the tag memory, then marking of block_size cells, then the done state.
// Clear: a sweep over the tag memory; a zero size allocate goes straight to the done state.
// One request at a time; a new request is taken only once the last one has handed off its result.
// After reset a clearing pass writes every tag to zero; no requests are taken until it ends.
// The result sits in an output register, so the next request may start while it waits.
`timescale 1ns / 1ps

module contiguous_fit_allocator
  import cfa_pkg::*;
#(
  parameter int unsigned MEM_CELLS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        fit_policy_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [TagW-1:0]   block_size_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [StartW-1:0] start_index_o
);

  localparam int unsigned AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
  localparam int unsigned LW = $clog2(MEM_CELLS + 1);
  localparam int unsigned CW = (LW > TagW) ? LW : TagW;
  localparam int unsigned SW = (AW > StartW) ? AW : StartW;
  localparam logic [LW-1:0] LastIdx = LW'(MEM_CELLS);

  state_e state_q, state_d;

  logic [TagW-1:0] mem_q [MEM_CELLS];
  logic [TagW-1:0] rd_data_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [TagW-1:0] wr_data;

  logic [1:0]        policy_q;
  logic [TagW-1:0]   size_q, size_d;
  logic [LW-1:0]     idx_q, idx_d, idx_nxt;
  logic [LW-1:0]     run_len_q, run_len_d;
  logic [AW-1:0]     run_start_q, run_start_d;
  logic [LW-1:0]     best_len_q, best_len_d;
  logic [AW-1:0]     best_start_q, best_start_d;
  logic              found_q, found_d;
  logic [LW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [1:0]        pend_status_q, pend_status_d;
  logic [StartW-1:0] pend_start_q, pend_start_d;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [StartW-1:0] start_q;

  logic in_fire, cell_free, run_fits, take, scan_end, clear_end, mark_end, out_free;
  logic [SW-1:0] best_start_wide;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign start_index_o = start_q;
  assign out_free      = !out_valid_q || out_ready_i;

  assign idx_nxt   = idx_q + 1'b1;
  assign cell_free = (idx_q != LastIdx) && (rd_data_q == '0);
  assign run_fits  = (run_len_q != '0) && (CW'(run_len_q) >= CW'(size_q));
  assign take      = run_fits && (!found_q ||
                     ((policy_q == POL_BEST) && (run_len_q < best_len_q)) ||
                     ((policy_q == POL_WORST) && (run_len_q > best_len_q)));
  assign scan_end  = (idx_q == LastIdx);
  assign clear_end = (idx_nxt == LastIdx);
  assign mark_end  = (rem_q == LW'(1));
  assign best_start_wide = SW'(best_start_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:  if (clear_end) state_d = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (req_type_i == REQ_CLEAR) begin
            state_d = S_CLEAR;
          end else if (block_size_i == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN:  if (scan_end) state_d = found_d ? S_MARK : S_DONE;
      S_MARK:  if (mark_end) state_d = S_DONE;
      S_CLEAR: if (clear_end) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = idx_q[AW-1:0];
    wr_data       = '0;
    size_d        = size_q;
    idx_d         = idx_q;
    run_len_d     = run_len_q;
    run_start_d   = run_start_q;
    best_len_d    = best_len_q;
    best_start_d  = best_start_q;
    found_d       = found_q;
    rem_d         = rem_q;
    wr_ptr_d      = wr_ptr_q;
    pend_status_d = pend_status_q;
    pend_start_d  = pend_start_q;
    unique case (state_q)
      S_INIT: begin
        wr_en = 1'b1;
        idx_d = clear_end ? '0 : idx_nxt;
      end
      S_IDLE: begin
        if (in_fire) begin
          size_d        = block_size_i;
          idx_d         = '0;
          run_len_d     = '0;
          found_d       = 1'b0;
          rd_en         = 1'b1;
          pend_status_d = (req_type_i == REQ_CLEAR) ? STAT_CLEARED : STAT_NOSPACE;
          pend_start_d  = '0;
        end
      end
      S_SCAN: begin
        idx_d   = idx_nxt;
        rd_en   = (idx_nxt != LastIdx) && !scan_end;
        rd_addr = idx_nxt[AW-1:0];
        if (cell_free) begin
          if (run_len_q == '0) run_start_d = idx_q[AW-1:0];
          run_len_d = run_len_q + 1'b1;
        end else begin
          run_len_d = '0;
          if (take) begin
            found_d      = 1'b1;
            best_start_d = run_start_q;
            best_len_d   = run_len_q;
          end
        end
        if (scan_end) begin
          wr_ptr_d = best_start_d;
          rem_d    = LW'(CW'(size_q));
        end
      end
      S_MARK: begin
        wr_en    = 1'b1;
        wr_addr  = wr_ptr_q;
        wr_data  = size_q;
        wr_ptr_d = wr_ptr_q + 1'b1;
        rem_d    = rem_q - 1'b1;
        if (mark_end) begin
          pend_status_d = STAT_ALLOC;
          pend_start_d  = best_start_wide[StartW-1:0];
        end
      end
      S_CLEAR: begin
        wr_en   = (rd_data_q == size_q);
        idx_d   = idx_nxt;
        rd_en   = !clear_end;
        rd_addr = idx_nxt[AW-1:0];
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      idx_q       <= '0;
      policy_q    <= POL_FIRST;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      if (cfg_valid_i) policy_q <= fit_policy_i;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q        <= size_d;
    run_len_q     <= run_len_d;
    run_start_q   <= run_start_d;
    best_len_q    <= best_len_d;
    best_start_q  <= best_start_d;
    rem_q         <= rem_d;
    wr_ptr_q      <= wr_ptr_d;
    pend_status_q <= pend_status_d;
    pend_start_q  <= pend_start_d;
    if (state_q == S_DONE && out_free) begin
      status_q <= pend_status_q;
      start_q  <= pend_start_q;
    end
  end

endmodule
